// ===== rtl/psmst_pkg.sv =====
// ----------------------------------------------------------------------------
// psmst_pkg
// Shared constants and types for the point set spanning tree weight unit.
// ----------------------------------------------------------------------------
package psmst_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 10;

    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int SQ_W     = 2 * COORD_BITS;
    localparam int DIST_W   = SQ_W + 1;
    localparam int CFG_W    = 22;
    localparam int CMP_W    = (DIST_W > CFG_W) ? DIST_W : CFG_W;
    localparam int WEIGHT_W = 31;
    localparam int SUM_W    = ((DIST_W > WEIGHT_W) ? DIST_W : WEIGHT_W) + 1;
    localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((WEIGHT_W + 7) / 8) * 8;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_SQ,
        S_UPD,
        S_SCAN,
        S_NEXT,
        S_DONE
    } state_t;

    // point handed down the chain during loading
    typedef struct packed {
        logic                  occ;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } pt_t;

    // running minimum handed down the chain during a scan
    typedef struct packed {
        logic                  found;
        logic [DIST_W-1:0]     d;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [IDX_W-1:0]      idx;
    } scan_t;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic                  shift;
        logic                  clear;
        logic                  start;
        logic                  upd;
        logic                  mark;
        logic [IDX_W-1:0]      mark_idx;
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        logic [CFG_W-1:0]      min_dist;
    } ctrl_t;

endpackage

// ===== rtl/psmst_cell.sv =====
// ----------------------------------------------------------------------------
// psmst_cell
// One point slot: stores a point, its link distance to the tree, and takes
// part in the chained minimum scan.
// ----------------------------------------------------------------------------
module psmst_cell
    import psmst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  ctrl_t            ctrl,
    input  pt_t              pt_in,
    output pt_t              pt_out,
    input  scan_t            scan_in,
    output scan_t            scan_out
);

    logic                  occ_reg;
    logic                  intree_reg;
    logic                  lv_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [DIST_W-1:0]     link_reg;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;
    scan_t                 scan_reg;
    scan_t                 scan_next;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [DIST_W-1:0]     dist_sq;
    logic                  cand;

    assign dx      = (x_reg > ctrl.cur_x) ? x_reg - ctrl.cur_x : ctrl.cur_x - x_reg;
    assign dy      = (y_reg > ctrl.cur_y) ? y_reg - ctrl.cur_y : ctrl.cur_y - y_reg;
    assign dist_sq = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
    assign cand    = occ_reg && !intree_reg && lv_reg;

    // strict compare keeps the lower-index candidate on a tie
    always_comb
    begin
        scan_next = scan_in;
        if (cand && (!scan_in.found || link_reg < scan_in.d))
        begin
            scan_next.found = 1'b1;
            scan_next.d     = link_reg;
            scan_next.x     = x_reg;
            scan_next.y     = y_reg;
            scan_next.idx   = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= 1'b0;
            intree_reg <= 1'b0;
            lv_reg     <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
                occ_reg <= 1'b0;
            else if (ctrl.shift)
                occ_reg <= pt_in.occ;
            if (ctrl.start)
            begin
                intree_reg <= (cell_idx == '0);
                lv_reg     <= 1'b0;
            end
            else
            begin
                if (ctrl.mark && ctrl.mark_idx == cell_idx)
                    intree_reg <= 1'b1;
                if (ctrl.upd && occ_reg && !intree_reg &&
                    CMP_W'(dist_sq) >= CMP_W'(ctrl.min_dist) &&
                    (!lv_reg || dist_sq < link_reg))
                    lv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            x_reg <= pt_in.x;
            y_reg <= pt_in.y;
        end
        sqx_reg  <= SQ_W'(dx) * SQ_W'(dx);
        sqy_reg  <= SQ_W'(dy) * SQ_W'(dy);
        scan_reg <= scan_next;
        if (ctrl.upd && occ_reg && !intree_reg &&
            CMP_W'(dist_sq) >= CMP_W'(ctrl.min_dist) &&
            (!lv_reg || dist_sq < link_reg))
            link_reg <= dist_sq;
    end

    assign pt_out   = '{occ: occ_reg, x: x_reg, y: y_reg};
    assign scan_out = scan_reg;

endmodule

// ===== rtl/point_set_min_spanning_tree_weight_unit.sv =====
// ----------------------------------------------------------------------------
// point_set_min_spanning_tree_weight_unit
// Loads a 2-D point set and returns the weight of its minimum spanning tree.
// ----------------------------------------------------------------------------
// Points stream in one per cycle while the block is loading, each shifted
// into a row of MAX_POINTS cells (newest at cell 0); points beyond
// MAX_POINTS are dropped. The request with tlast set starts Prim's method:
// cell 0 seeds the tree, then each of up to n-1 tree steps squares the
// offsets from the current point in every cell, updates the link distances,
// lets the running minimum travel down the cell chain, and takes the winner.
// The result goes to an output register; tree_weight is 0 when connected is
// 0, and it saturates at 2^31-1. No points are taken while a set is being
// processed. min_dist_sq may be written while the block is idle.
// ----------------------------------------------------------------------------
module point_set_min_spanning_tree_weight_unit
    import psmst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: min_dist_sq
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,
    // input points
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // x_coord, y_coord, zero pad
    input  logic                  s_tlast,   // last_point
    // result
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // tree_weight, zero pad
    output logic                  m_tuser    // connected
);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      remain_reg;
    logic [IDX_W-1:0]      scan_cnt_reg;
    logic [WEIGHT_W-1:0]   total_reg;
    logic [COORD_BITS-1:0] cur_x_reg;
    logic [COORD_BITS-1:0] cur_y_reg;
    logic [CFG_W-1:0]      min_dist_reg;
    logic                  conn_reg;     // outcome of the current set
    logic                  out_valid_reg;
    logic [WEIGHT_W-1:0]   out_weight_reg;
    logic                  out_conn_reg;

    logic                  in_acc;
    logic                  store;
    logic [SUM_W-1:0]      sum;
    ctrl_t                 ctrl;

    pt_t                   pt_chain   [0:MAX_POINTS];
    scan_t                 scan_chain [0:MAX_POINTS];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_LOAD);
    assign in_acc    = s_tvalid && s_tready;
    assign store     = in_acc && (count_reg < CNT_W'(MAX_POINTS));
    assign sum       = SUM_W'(total_reg) + SUM_W'(scan_chain[MAX_POINTS].d);

    assign pt_chain[0]   = '{occ: 1'b1, x: s_tdata[COORD_BITS-1:0],
                             y: s_tdata[2*COORD_BITS-1:COORD_BITS]};
    assign scan_chain[0] = '0;

    // cell row
    for (genvar g = 0; g < MAX_POINTS; g++)
    begin : g_cell
        psmst_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(g)),
            .ctrl     (ctrl),
            .pt_in    (pt_chain[g]),
            .pt_out   (pt_chain[g+1]),
            .scan_in  (scan_chain[g]),
            .scan_out (scan_chain[g+1])
        );
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.shift    = store;
        ctrl.clear    = 1'b0;
        ctrl.start    = (state_reg == S_START);
        ctrl.upd      = (state_reg == S_UPD);
        ctrl.mark     = (state_reg == S_NEXT) && scan_chain[MAX_POINTS].found;
        ctrl.mark_idx = scan_chain[MAX_POINTS].idx;
        ctrl.cur_x    = cur_x_reg;
        ctrl.cur_y    = cur_y_reg;
        ctrl.min_dist = min_dist_reg;
        state_next    = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc && s_tlast)
                    state_next = S_START;
            end
            S_START:
            begin
                // a lone point is a tree of weight zero
                state_next = (count_reg == CNT_W'(1)) ? S_DONE : S_SQ;
            end
            S_SQ:   state_next = S_UPD;
            S_UPD:  state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_cnt_reg == IDX_W'(MAX_POINTS - 1))
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (!scan_chain[MAX_POINTS].found || remain_reg == CNT_W'(1))
                    state_next = S_DONE;
                else
                    state_next = S_SQ;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    ctrl.clear = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            min_dist_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                min_dist_reg <= cfg_data;
            if (store)
                count_reg <= count_reg + CNT_W'(1);
            if (state_reg == S_DONE && ctrl.clear)
            begin
                count_reg     <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_cnt_reg <= (state_reg == S_SCAN) ? scan_cnt_reg + IDX_W'(1) : '0;
        case (state_reg)
            S_START:
            begin
                cur_x_reg  <= pt_chain[1].x;
                cur_y_reg  <= pt_chain[1].y;
                remain_reg <= count_reg - CNT_W'(1);
                total_reg  <= '0;
                conn_reg   <= 1'b1;
            end
            S_NEXT:
            begin
                if (scan_chain[MAX_POINTS].found)
                begin
                    cur_x_reg  <= scan_chain[MAX_POINTS].x;
                    cur_y_reg  <= scan_chain[MAX_POINTS].y;
                    remain_reg <= remain_reg - CNT_W'(1);
                    total_reg  <= (sum > SUM_W'(WEIGHT_MAX)) ? WEIGHT_MAX
                                                             : sum[WEIGHT_W-1:0];
                end
                else
                    conn_reg <= 1'b0;
            end
            S_DONE:
            begin
                if (ctrl.clear)
                begin
                    out_weight_reg <= conn_reg ? total_reg : '0;
                    out_conn_reg   <= conn_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_weight_reg);
    assign m_tuser  = out_conn_reg;

    // a tree step never starts with no edges left to add
    a_step_remain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQ |-> remain_reg != '0)
        else $error("tree step with nothing remaining");

    // the chain winner always comes from a stored point
    a_winner_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NEXT && scan_chain[MAX_POINTS].found)
            |-> CNT_W'(scan_chain[MAX_POINTS].idx) < count_reg)
        else $error("scan winner outside stored points");

    // a full store drops further points
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && count_reg == CNT_W'(MAX_POINTS)) |=> count_reg == $past(count_reg))
        else $error("point count moved while store full");

    // a result is only posted from the done state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result posted outside done state");

endmodule
